// File: design/isu_pkg.sv
package isu_pkg;

   localparam int CODE_W       = 16;
   localparam int INDEX_W      = 6;
   localparam int RESULT_SLOTS = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_REVERSED = 2'd2
   } isu_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT_PREP,
      ST_EMIT
   } isu_state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_input;
      logic proc_entry;
      logic finish;
      logic out_load;
      logic out_empty;
      logic out_last;
   } isu_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic reversed;
      logic full_hit;
      logic out_free;
   } isu_sts_type;

endpackage

// File: design/isu_if.sv
interface isu_req_if import isu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] range_low;
   logic [CODE_W-1:0] range_high;

   modport source (output valid, range_low, range_high, input ready);
   modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface isu_rsp_if import isu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] entry_index;
   logic [CODE_W-1:0]  entry_low;
   logic [CODE_W-1:0]  entry_high;
   logic               entry_valid;
   logic               last_entry;
   logic [1:0]         insert_status;

   modport source (output valid, entry_index, entry_low, entry_high, entry_valid,
                   last_entry, insert_status, input ready);
   modport sink   (input valid, entry_index, entry_low, entry_high, entry_valid,
                   last_entry, insert_status, output ready);
endinterface

// File: design/isu_ctrl.sv
module isu_ctrl import isu_pkg::*; #(
   parameter int MAX_RANGES = 64,
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
   localparam int CW = $clog2(MAX_RANGES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  isu_sts_type        sts,
   input  logic [CW-1:0]      count,
   output isu_cmd_type        cmd,
   output logic [IW-1:0]      rd_idx,
   output logic [INDEX_W-1:0] out_index
);

   isu_state_type state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [CW-1:0] n_items;
   logic          last_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         emit_ff  <= emit_in;
      end
   end

   // at most RESULT_SLOTS items go out per request
   assign n_items  = (int'(count) > RESULT_SLOTS) ? CW'(RESULT_SLOTS) : count;
   assign last_hit = (({1'b0, emit_ff} + {{CW{1'b0}}, 1'b1}) == {1'b0, n_items});
   assign out_index = INDEX_W'(emit_ff);

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      emit_in   = emit_ff;
      cmd       = '0;
      rd_idx    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_input = 1'b1;
               scan_in        = '0;
               if (sts.reversed) begin
                  state_in = ST_EMIT_PREP;
               end else if (count == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read entry scan_ff, process entry scan_ff-1 (read data is registered, so it arrives in the next cycle)
            rd_idx         = scan_ff[IW-1:0];
            cmd.proc_entry = (scan_ff != '0);
            if (cmd.proc_entry && sts.full_hit) begin
               state_in = ST_EMIT_PREP;
            end else if (scan_ff == count) begin
               state_in = ST_FINISH;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT_PREP;
         end
         ST_EMIT_PREP: begin
            rd_idx   = '0;
            emit_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rd_idx = emit_ff[IW-1:0];
            if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_empty = (count == '0);
               cmd.out_last  = cmd.out_empty || last_hit;
               if (cmd.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + CW'(1);
                  rd_idx  = emit_in[IW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register loaded while occupied");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !sts.out_free) |=> (state_ff == ST_EMIT && emit_ff == $past(emit_ff)))
      else $error("emit position moved during a stall");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= count))
      else $error("scan ran past the stored list");

endmodule

// File: design/isu_dpath.sv
module isu_dpath import isu_pkg::*; #(
   parameter int MAX_RANGES = 64,
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
   localparam int CW = $clog2(MAX_RANGES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  isu_cmd_type        cmd,
   output isu_sts_type        sts,
   input  logic [CODE_W-1:0]  req_low,
   input  logic [CODE_W-1:0]  req_high,
   input  logic [IW-1:0]      rd_idx,
   input  logic [INDEX_W-1:0] out_index_in,
   output logic [CW-1:0]      count,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [INDEX_W-1:0] rsp_index,
   output logic [CODE_W-1:0]  rsp_low,
   output logic [CODE_W-1:0]  rsp_high,
   output logic               rsp_entry_valid,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);

   localparam int MEM_DEPTH = 2 * (1 << IW);
   localparam logic [CODE_W:0] ONE_X = {{CODE_W{1'b0}}, 1'b1};

   // two banks: read the live list, write the rebuilt one
   logic [2*CODE_W-1:0] range_mem [MEM_DEPTH];
   logic [2*CODE_W-1:0] rdata_ff;

   logic [CODE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CODE_W-1:0] cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   logic              placed_ff, placed_in;
   logic [CW-1:0]     wptr_ff, wptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              bank_ff, bank_in;
   isu_status_type    status_ff, status_in;

   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_nx;
   logic [CODE_W-1:0]  out_low_ff, out_low_in, out_high_ff, out_high_in;
   logic               out_ev_ff, out_ev_in, out_last_ff, out_last_in;
   logic [1:0]         out_status_ff, out_status_in;

   logic [CODE_W-1:0] s_val, e_val, eff_lo, eff_hi;
   logic              passed, touch, scan_insert, at_max, finish_full;
   logic              wr_en;
   logic [CODE_W-1:0] wr_lo, wr_hi;

   assign s_val  = rdata_ff[2*CODE_W-1:CODE_W];
   assign e_val  = rdata_ff[CODE_W-1:0];
   assign eff_lo = placed_ff ? cur_lo_ff : lo_ff;
   assign eff_hi = placed_ff ? cur_hi_ff : hi_ff;

   // 17-bit compares: an entry ending at the top code never touches code 0
   assign passed      = !placed_ff && ({1'b0, lo_ff} > ({1'b0, e_val} + ONE_X));
   assign touch       = ({1'b0, s_val} <= ({1'b0, eff_hi} + ONE_X));
   assign scan_insert = !placed_ff && !passed && !touch;
   assign at_max      = (count_ff == CW'(MAX_RANGES));
   assign finish_full = at_max && !placed_ff;

   assign sts.reversed = (req_low > req_high);
   assign sts.full_hit = at_max && scan_insert;
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign count        = count_ff;

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cur_lo_in = cur_lo_ff;
      cur_hi_in = cur_hi_ff;
      placed_in = placed_ff;
      wptr_in   = wptr_ff;
      count_in  = count_ff;
      bank_in   = bank_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_lo     = s_val;
      wr_hi     = e_val;
      if (cmd.take_input) begin
         lo_in     = req_low;
         hi_in     = req_high;
         placed_in = 1'b0;
         wptr_in   = '0;
         status_in = sts.reversed ? STATUS_REVERSED : STATUS_OK;
      end
      if (cmd.proc_entry) begin
         if (sts.full_hit) begin
            status_in = STATUS_FULL;
         end else if (passed) begin
            // entry lies wholly below the new range: copy it across
            wr_en   = 1'b1;
            wptr_in = wptr_ff + CW'(1);
         end else if (touch) begin
            placed_in = 1'b1;
            cur_lo_in = (s_val < eff_lo) ? s_val : eff_lo;
            cur_hi_in = (e_val > eff_hi) ? e_val : eff_hi;
         end else begin
            // pending range is closed: write it, entry becomes pending
            wr_en     = 1'b1;
            wr_lo     = eff_lo;
            wr_hi     = eff_hi;
            wptr_in   = wptr_ff + CW'(1);
            cur_lo_in = s_val;
            cur_hi_in = e_val;
            placed_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         if (finish_full) begin
            status_in = STATUS_FULL;
         end else begin
            wr_en    = 1'b1;
            wr_lo    = eff_lo;
            wr_hi    = eff_hi;
            count_in = wptr_ff + CW'(1);
            bank_in  = ~bank_ff;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_index_nx  = out_index_ff;
      out_low_in    = out_low_ff;
      out_high_in   = out_high_ff;
      out_ev_in     = out_ev_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_index_nx  = cmd.out_empty ? '0 : out_index_in;
         out_low_in    = cmd.out_empty ? '0 : s_val;
         out_high_in   = cmd.out_empty ? '0 : e_val;
         out_ev_in     = !cmd.out_empty;
         out_last_in   = cmd.out_last;
         out_status_in = status_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff    <= 1'b0;
         wptr_ff      <= '0;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         placed_ff    <= placed_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_lo_ff     <= cur_lo_in;
      cur_hi_ff     <= cur_hi_in;
      status_ff     <= status_in;
      out_index_ff  <= out_index_nx;
      out_low_ff    <= out_low_in;
      out_high_ff   <= out_high_in;
      out_ev_ff     <= out_ev_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[{~bank_ff, wptr_ff[IW-1:0]}] <= {wr_lo, wr_hi};
      end
      rdata_ff <= range_mem[{bank_ff, rd_idx}];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_index       = out_index_ff;
   assign rsp_low         = out_low_ff;
   assign rsp_high        = out_high_ff;
   assign rsp_entry_valid = out_ev_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_status      = out_status_ff;

   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wptr_ff < CW'(MAX_RANGES)))
      else $error("rebuild write beyond table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES))
      else $error("entry count above table size");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && finish_full) |=> (count_ff == $past(count_ff) && bank_ff == $past(bank_ff)))
      else $error("dropped request changed the list");

endmodule

// File: design/interval_set_merge_insert_unit.sv
// Sorted interval set with merging insert.
// req_bus carries one inclusive code range per request (range_low, range_high).
// The range is merged into a sorted list of disjoint, non-touching ranges held
// in a two-bank memory: the live bank is streamed once, the rebuilt list is
// written to the other bank, and the banks swap at the end of a successful insert.
// After each request rsp_bus returns the whole list, one item per entry in
// order, last_entry on the final one; an empty list gives one item with
// entry_valid low. insert_status flags a full table or a reversed range and
// is repeated on every item of the request.
// Steps per request: accept, scan (one memory read per entry, with the read
// data registered), finish, read-prime, then one item per cycle while
// rsp_bus.ready is high. A reversed range skips the scan and finish.
// req_bus.ready is high only between requests; the next request can be taken
// while the last item still waits in the output register.
// A stall on rsp_bus holds the output register and the emit position.
// Reset empties the list (count zero); memory contents need no clearing.
module interval_set_merge_insert_unit import isu_pkg::*; #(
   parameter int MAX_RANGES = 64
) (
   input logic     clock,
   input logic     reset,
   isu_req_if.sink   req_bus,
   isu_rsp_if.source rsp_bus
);

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   isu_cmd_type        cmd;
   isu_sts_type        sts;
   logic [CW-1:0]      count;
   logic [IW-1:0]      rd_idx;
   logic [INDEX_W-1:0] out_index;

   // sequencing: scan, finish, emit
   isu_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .count     (count),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .out_index (out_index)
   );

   // list memory, merge logic and output register
   isu_dpath #(.MAX_RANGES(MAX_RANGES)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_low         (req_bus.range_low),
      .req_high        (req_bus.range_high),
      .rd_idx          (rd_idx),
      .out_index_in    (out_index),
      .count           (count),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_index       (rsp_bus.entry_index),
      .rsp_low         (rsp_bus.entry_low),
      .rsp_high        (rsp_bus.entry_high),
      .rsp_entry_valid (rsp_bus.entry_valid),
      .rsp_last        (rsp_bus.last_entry),
      .rsp_status      (rsp_bus.insert_status)
   );

endmodule
